### rtl/rfa_pkg.sv
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the region Fst accumulator: field widths,
// function codes and the request and response of the iterative divider.
// ----------------------------------------------------------------------------
package rfa_pkg;

  // stream payload widths
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 56;

  // field and state widths
  localparam int CNT_W  = 16;
  localparam int REG_W  = 10;
  localparam int S1_W   = 40;
  localparam int TOT_W  = 21;
  localparam int SUM_W  = 32;
  localparam int FST_W  = 17;
  localparam int MUL_W  = 21;
  localparam int PROD_W = 2 * MUL_W;

  // divider datapath
  localparam int DIV_W      = 64;
  localparam int QUO_W      = 36;
  localparam int STEP_W     = 6;
  localparam int TERM_STEPS = 36;
  localparam int FST_STEPS  = 18;

  // Fst of one in Q1.16
  localparam logic [FST_W-1:0] FST_ONE = 17'h10000;

  // function codes carried in tuser
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // divider request: pre-shifted divisor, number of quotient bits
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  dsh;
    logic [STEP_W-1:0] steps;
  } rfa_div_req_t;

  // divider response: one-cycle done pulse, quotient held until next start
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } rfa_div_rsp_t;

endpackage

### rtl/rfa_ram.sv
// ----------------------------------------------------------------------------
// rfa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read at one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/rfa_div.sv
// ----------------------------------------------------------------------------
// rfa_div
// Iterative restoring divider, one quotient bit per cycle. The divisor comes
// pre-shifted to the weight of the top quotient bit.
// ----------------------------------------------------------------------------
module rfa_div (
  input  logic                 clk,
  input  logic                 rst,
  input  rfa_pkg::rfa_div_req_t req,
  output rfa_pkg::rfa_div_rsp_t rsp
);

  import rfa_pkg::*;

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsh;
  logic [QUO_W-1:0]  quo;
  logic              fits;

  // one trial subtraction per cycle
  assign fits = (rem >= dsh);

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder, divisor and quotient datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= req.dsh;
      quo <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      quo <= {quo[QUO_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

### rtl/region_fst_accumulator_unit.sv
// ----------------------------------------------------------------------------
// region_fst_accumulator_unit
// Per-SNP fixation index from group allele counts, summed per region.
// ----------------------------------------------------------------------------
// Input stream (s_*): one transaction per group count (tuser = 0) or per
// region read (tuser = 1); tlast marks the final group of a SNP. Output
// stream (m_*): one transaction per final group and per read, none for
// other groups.
// A count transaction takes one multiply for n*n, then 36 steps of the
// shared bit-serial divider for n^2*2^20/(n+m). A final group adds four
// passes through the shared 21x21 multiplier, 18 divider steps for the Fst
// quotient and a read-modify-write of the region sum RAM. One item is
// worked at a time; s_tready is high only while the sequencer is idle.
// After reset the region RAM is cleared, one entry a cycle, with
// s_tready low.
// Results sit in an output register: the next item is accepted while a
// result waits, and the sequencer holds at its own result until the
// previous one has been taken.
// ----------------------------------------------------------------------------
module region_fst_accumulator_unit #(
  parameter int REGION_COUNT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // alt_count [15:0], ref_count [31:16], region [41:32], zero pad
  input  logic [rfa_pkg::S_TDATA_W-1:0]   s_tdata,
  // func
  input  logic                            s_tuser,
  // last_group
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // snp_fst [16:0], region_total [48:17], zero pad
  output logic [rfa_pkg::M_TDATA_W-1:0]   m_tdata,
  // snp_skipped
  output logic                            m_tuser
);

  import rfa_pkg::*;

  localparam int AW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_WB,
    ST_T_MUL,
    ST_T_DSTART,
    ST_T_DWAIT,
    ST_ACCUM,
    ST_CHECK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_AA,
    ST_MUL_DEN,
    ST_F_CMP,
    ST_F_DWAIT,
    ST_REG_UPD,
    ST_DONE
  } state_t;

  state_t state;

  // captured item
  logic             last_r;
  logic [CNT_W-1:0] n_r;
  logic [CNT_W-1:0] m_r;
  logic [REG_W-1:0] region_r;
  logic             in_range_r;

  // snp accumulators
  logic [S1_W-1:0]  s1;
  logic [TOT_W-1:0] n_all;
  logic [TOT_W-1:0] a_tot;

  // fst datapath
  logic [PROD_W-1:0] prod;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [DIV_W-1:0]  lhs;
  logic [DIV_W-1:0]  rhs;
  logic [FST_W-1:0]  fst_r;
  logic              skip_r;

  // pending result
  logic [FST_W-1:0] res_fst;
  logic [SUM_W-1:0] res_total;
  logic             res_skip;

  // clearing pass and region ram
  logic [AW-1:0]      clr_cnt;
  logic [AW-1:0]      ram_addr;
  logic               ram_we;
  logic [SUM_W-1:0]   ram_wdata;
  logic [SUM_W-1:0]   ram_rdata;
  logic [AW+REG_W-1:0] region_wide;

  // divider
  rfa_div_req_t div_req;
  rfa_div_rsp_t div_rsp;

  // combinational helpers
  logic [CNT_W:0]   nm;
  logic [S1_W:0]    s1_sum;
  logic [TOT_W:0]   n_sum;
  logic [TOT_W:0]   a_sum;
  logic [QUO_W-1:0] term;
  logic [SUM_W:0]   upd_wide;
  logic [SUM_W-1:0] upd_sum;
  logic [FST_W-1:0] fst_q;
  logic             snp_empty;
  logic             in_range_in;

  assign s_tready = (state == ST_IDLE);

  assign in_range_in = ({7'b0, s_tdata[41:32]} < 17'(REGION_COUNT));
  assign region_wide = {{AW{1'b0}}, region_r};

  // group term and saturating accumulator sums
  assign nm     = {1'b0, n_r} + {1'b0, m_r};
  assign term   = (nm == '0) ? '0 : div_rsp.quo;
  assign s1_sum = {1'b0, s1} + (S1_W + 1)'(term);
  assign n_sum  = {1'b0, n_all} + (TOT_W + 1)'(nm);
  assign a_sum  = {1'b0, a_tot} + (TOT_W + 1)'(n_r);

  // no data or monomorphic
  assign snp_empty = (n_all == '0) || (a_tot == '0) || (a_tot >= n_all);

  // fst quotient clipped at one
  assign fst_q = (div_rsp.quo[FST_W] || (div_rsp.quo[FST_W-1:0] > FST_ONE)) ?
                 FST_ONE : div_rsp.quo[FST_W-1:0];

  // saturating region update
  assign upd_wide = {1'b0, ram_rdata} + (SUM_W + 1)'(fst_r);
  assign upd_sum  = upd_wide[SUM_W] ? '1 : upd_wide[SUM_W-1:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_T_MUL: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(n_r);
      end
      ST_MUL_LO: begin
        mul_a = MUL_W'(s1[19:0]);
        mul_b = n_all;
      end
      ST_MUL_HI: begin
        mul_a = MUL_W'(s1[39:20]);
        mul_b = n_all;
      end
      ST_MUL_AA: begin
        mul_a = a_tot;
        mul_b = a_tot;
      end
      ST_MUL_DEN: begin
        mul_a = a_tot;
        mul_b = n_all - a_tot;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // registered product
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // divider request
  always_comb begin
    div_req = '0;
    case (state)
      ST_T_DSTART: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'({prod[31:0], 20'b0});
        div_req.dsh   = DIV_W'({nm, 35'b0});
        div_req.steps = STEP_W'(TERM_STEPS);
      end
      ST_F_CMP: begin
        div_req.start = (lhs > rhs);
        div_req.num   = lhs - rhs;
        div_req.dsh   = DIV_W'({prod, 21'b0});
        div_req.steps = STEP_W'(FST_STEPS);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  rfa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // region ram port control
  always_comb begin
    ram_addr  = region_wide[AW-1:0];
    ram_we    = 1'b0;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_addr = clr_cnt;
        ram_we   = 1'b1;
      end
      ST_RD_WB: begin
        ram_we = in_range_r;
      end
      ST_REG_UPD: begin
        ram_we    = in_range_r && !skip_r;
        ram_wdata = upd_sum;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  rfa_ram #(
    .WIDTH (SUM_W),
    .DEPTH (REGION_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // sequencer, accumulators and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      s1       <= '0;
      n_all    <= '0;
      a_tot    <= '0;
    end else begin
      // a new result loaded in ST_DONE keeps the output valid
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(REGION_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            last_r     <= s_tlast;
            n_r        <= s_tdata[15:0];
            m_r        <= s_tdata[31:16];
            region_r   <= s_tdata[41:32];
            in_range_r <= in_range_in;
            state      <= (s_tuser == FUNC_READ) ? ST_RD_WAIT : ST_T_MUL;
          end
        end
        ST_RD_WAIT: begin
          state <= ST_RD_WB;
        end
        ST_RD_WB: begin
          res_fst   <= '0;
          res_total <= in_range_r ? ram_rdata : '0;
          res_skip  <= 1'b0;
          state     <= ST_DONE;
        end
        ST_T_MUL: begin
          state <= (nm == '0) ? ST_ACCUM : ST_T_DSTART;
        end
        ST_T_DSTART: begin
          state <= ST_T_DWAIT;
        end
        ST_T_DWAIT: begin
          if (div_rsp.done) begin
            state <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          s1    <= s1_sum[S1_W] ? '1 : s1_sum[S1_W-1:0];
          n_all <= n_sum[TOT_W] ? '1 : n_sum[TOT_W-1:0];
          a_tot <= a_sum[TOT_W] ? '1 : a_sum[TOT_W-1:0];
          state <= last_r ? ST_CHECK : ST_IDLE;
        end
        ST_CHECK: begin
          fst_r  <= '0;
          skip_r <= snp_empty;
          state  <= snp_empty ? ST_REG_UPD : ST_MUL_LO;
        end
        ST_MUL_LO: begin
          state <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          lhs   <= DIV_W'(prod);
          state <= ST_MUL_AA;
        end
        ST_MUL_AA: begin
          lhs   <= lhs + DIV_W'({prod, 20'b0});
          state <= ST_MUL_DEN;
        end
        ST_MUL_DEN: begin
          rhs   <= DIV_W'({prod, 20'b0});
          state <= ST_F_CMP;
        end
        ST_F_CMP: begin
          state <= (lhs > rhs) ? ST_F_DWAIT : ST_REG_UPD;
        end
        ST_F_DWAIT: begin
          if (div_rsp.done) begin
            fst_r <= fst_q;
            state <= ST_REG_UPD;
          end
        end
        ST_REG_UPD: begin
          res_fst   <= fst_r;
          res_skip  <= skip_r;
          res_total <= !in_range_r ? '0 : (skip_r ? ram_rdata : upd_sum);
          s1        <= '0;
          n_all     <= '0;
          a_tot     <= '0;
          state     <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'b0, res_total, res_fst};
            m_tuser  <= res_skip;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
